FILE: hdl/abd_pkg.sv
// Package for the audio bitcrusher: shared types, register codes and constants.
// Used by the front, the back and the top level; it depends on nothing else.
package abd_pkg;

	// Default sample width, Q1.(SAMPLE_BITS-1).
	localparam int SAMPLE_BITS_DEF = 16;

	// Largest DPCM step width; wider settings are cut back to this.
	localparam int MAX_SLOPE_BITS = 4;

	// Depth of the queues between the parts of the block.
	localparam int QUEUE_DEPTH = 2;

	// Phase accumulator and interpolation weight widths, Q16.
	localparam int PHASE_W = 26;
	localparam int T_W = 17;
	localparam int ONE_Q16 = 65536;
	localparam int HALF_Q16 = 32768;

	// Gain is Q4.12.
	localparam int GAIN_FRAC = 12;
	localparam int GAIN_HALF = 2048;

	// Configuration port.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DPCM_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_BITS = 3'd4;

	// Register values after reset.
	localparam logic [23:0] RST_HOLD_STEP = 24'd65536;
	localparam logic [15:0] RST_GAIN = 16'd4096;
	localparam logic [3:0] RST_BIT_DEPTH = 4'd7;
	localparam logic RST_DPCM_MODE = 1'b0;
	localparam logic [2:0] RST_SLOPE_BITS = 3'd1;

	// Effective configuration, already limited to the ranges the datapath handles.
	typedef struct packed {
		logic [23:0] hold_step; // at least 1.0
		logic [15:0] gain;
		logic [4:0]  depth;     // quantiser bits b
		logic [4:0]  shift;     // SAMPLE_BITS - b
		logic        dpcm;
		logic [2:0]  slope;     // DPCM step bits s
	} cfg_t;

	typedef enum logic [1:0] {
		FS_EMPTY,
		FS_PREV,
		FS_CUR
	} front_state_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_QUANT,
		BS_EMIT
	} back_state_t;

endpackage

FILE: hdl/audio_bitcrusher_dpcm.sv
// Audio bitcrusher: gain and clip, sample-and-hold rate reduction with linear
// interpolation at each hold point, then a PCM or DPCM amplitude quantiser. Samples
// enter through a queue-style push port and one result leaves per sample through a
// queue-style pop port. The single multiplier of the front forms the gain products
// of the previous and then the current sample, and the front can take a new sample
// while it hands the last one on. The back works on one sample at a time: at a hold
// point it forms the interpolation product, rounds to a level and chooses the level,
// and otherwise it hands on the held level. A two-entry queue decouples the front
// from the back and another holds results.
// Configuration is written through a valid/ready port that is always ready.
// Depends on abd_pkg, abd_fifo, abd_front and abd_back.
module audio_bitcrusher_dpcm
	import abd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          clip_start,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [SAMPLE_BITS:0]   crushed,
	output logic signed [15:0]            level_index,
	output logic                          hold_point
);

	localparam int MidW = 2 * (SAMPLE_BITS + 1) + T_W + 2;
	localparam int OutW = SAMPLE_BITS + 1 + 16 + 1;

	logic [23:0] hold_step_q;
	logic [15:0] gain_q;
	logic [3:0]  bit_depth_q;
	logic        dpcm_mode_q;
	logic [2:0]  slope_bits_q;

	logic [4:0] depth_w;
	logic [4:0] depth_eff;
	logic [2:0] slope_eff;
	cfg_t       cfg_eff;

	logic            mid_push;
	logic [MidW-1:0] mid_wdata;
	logic            mid_full;
	logic            mid_pop;
	logic [MidW-1:0] mid_rdata;
	logic            mid_empty;

	logic            out_push;
	logic [OutW-1:0] out_wdata;
	logic            out_full;
	logic [OutW-1:0] out_rdata;

	// Configuration registers; every transaction is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_step_q <= RST_HOLD_STEP;
			gain_q <= RST_GAIN;
			bit_depth_q <= RST_BIT_DEPTH;
			dpcm_mode_q <= RST_DPCM_MODE;
			slope_bits_q <= RST_SLOPE_BITS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HOLD_STEP: begin
					hold_step_q <= cfg_data[23:0];
				end
				CFG_GAIN: begin
					gain_q <= cfg_data[15:0];
				end
				CFG_BIT_DEPTH: begin
					bit_depth_q <= cfg_data[3:0];
				end
				CFG_DPCM_MODE: begin
					dpcm_mode_q <= cfg_data[0];
				end
				CFG_SLOPE_BITS: begin
					slope_bits_q <= cfg_data[2:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Settings out of range are limited to the nearest usable value.
	assign depth_w = {1'b0, bit_depth_q};
	assign depth_eff = (depth_w == 5'd0) ? 5'd1 :
		(depth_w > 5'(SAMPLE_BITS - 1)) ? 5'(SAMPLE_BITS - 1) : depth_w;
	assign slope_eff = (slope_bits_q == 3'd0) ? 3'd1 :
		(slope_bits_q > 3'(MAX_SLOPE_BITS)) ? 3'(MAX_SLOPE_BITS) : slope_bits_q;

	always_comb begin
		cfg_eff.hold_step = (hold_step_q < 24'(ONE_Q16)) ? 24'(ONE_Q16) : hold_step_q;
		cfg_eff.gain = gain_q;
		cfg_eff.depth = depth_eff;
		cfg_eff.shift = 5'(SAMPLE_BITS) - depth_eff;
		cfg_eff.dpcm = dpcm_mode_q;
		cfg_eff.slope = slope_eff;
	end

	// Front: accept, phase and gain.
	abd_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.clip_start(clip_start),
		.cfg(cfg_eff),
		.mid_push(mid_push),
		.mid_data(mid_wdata),
		.mid_full(mid_full)
	);

	// Queue between front and back.
	abd_fifo #(
		.WIDTH(MidW),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(mid_push),
		.wdata(mid_wdata),
		.full(mid_full),
		.pop(mid_pop),
		.rdata(mid_rdata),
		.empty(mid_empty)
	);

	// Back: interpolation and quantiser.
	abd_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_eff),
		.mid_data(mid_rdata),
		.mid_empty(mid_empty),
		.mid_pop(mid_pop),
		.out_push(out_push),
		.out_data(out_wdata),
		.out_full(out_full)
	);

	// Result queue.
	abd_fifo #(
		.WIDTH(OutW),
		.DEPTH(QUEUE_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(out_push),
		.wdata(out_wdata),
		.full(out_full),
		.pop(pop),
		.rdata(out_rdata),
		.empty(empty)
	);

	assign crushed = out_rdata[OutW-1 -: SAMPLE_BITS + 1];
	assign level_index = out_rdata[16:1];
	assign hold_point = out_rdata[0];

`ifndef NO_ASSERTIONS
	// A level value is a whole multiple of the level spacing.
	a_level_grid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((crushed & (((SAMPLE_BITS + 1)'(1) << cfg_eff.shift)
			- (SAMPLE_BITS + 1)'(1))) == '0))
		else $error("crushed value off the level grid");

	// One quantiser bit leaves only the levels zero and full scale.
	a_one_bit_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && hold_point && cfg_eff.depth == 5'd1) |->
			(crushed == '0 || crushed == ((SAMPLE_BITS + 1)'(1) << (SAMPLE_BITS - 1))))
		else $error("one-bit quantiser gave a level other than zero or full scale");
`endif

endmodule

FILE: hdl/abd_fifo.sv
// Small first-in first-out queue built from registers.
// Generic; it uses no package.
module abd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CntW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	// Status and the head entry.
	assign full = (cnt_q == CntW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

FILE: hdl/abd_front.sv
// Front of the bitcrusher: takes samples, runs the hold-point phase accumulator
// and applies the gain and clip to both samples. Depends on abd_pkg.
module abd_front
	import abd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int MidW = 2 * (SAMPLE_BITS + 1) + T_W + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          clip_start,
	input  cfg_t                          cfg,
	output logic                          mid_push,
	output logic [MidW-1:0]               mid_data,
	input  logic                          mid_full
);

	localparam int ProdW = SAMPLE_BITS + 17;
	localparam logic signed [ProdW-1:0] FullPos = ProdW'(1) <<< (SAMPLE_BITS - 1);
	localparam logic signed [ProdW-1:0] FullNeg = -FullPos;

	front_state_t state_q;
	front_state_t state_d;
	logic accept;

	logic signed [PHASE_W-1:0] npos_q;
	logic signed [PHASE_W-1:0] pos;
	logic signed [PHASE_W-1:0] npos_d;
	logic hold_w;
	logic [T_W-1:0] t_w;

	logic signed [SAMPLE_BITS-1:0] prev_input_q;
	logic signed [SAMPLE_BITS-1:0] cur_raw_s1;
	logic signed [SAMPLE_BITS-1:0] prev_raw_s1;
	logic hold_s1;
	logic start_s1;
	logic [T_W-1:0] t_s1;
	logic signed [SAMPLE_BITS:0] sprev_s1;

	logic signed [SAMPLE_BITS-1:0] mul_in;
	logic signed [ProdW-1:0] prod;
	logic signed [ProdW-1:0] rnd;
	logic signed [SAMPLE_BITS:0] scaled;

	assign accept = push && !full;

	// Phase accumulator: a clip start puts the hold point on this sample.
	assign pos = clip_start ? '0 : npos_q;
	assign hold_w = pos[PHASE_W-1] || (pos == '0);
	assign t_w = T_W'(pos + PHASE_W'(ONE_Q16));
	assign npos_d = pos + (hold_w ? $signed({2'b00, cfg.hold_step}) : PHASE_W'(0))
		- PHASE_W'(ONE_Q16);

	// One multiplier serves the previous sample, then the current one.
	assign mul_in = (state_q == FS_PREV) ? prev_raw_s1 : cur_raw_s1;
	assign prod = mul_in * $signed({1'b0, cfg.gain});
	assign rnd = (prod + ProdW'(GAIN_HALF)) >>> GAIN_FRAC;
	assign scaled = (rnd > FullPos) ? FullPos[SAMPLE_BITS:0] :
		(rnd < FullNeg) ? FullNeg[SAMPLE_BITS:0] : rnd[SAMPLE_BITS:0];

	assign mid_data = {sprev_s1, scaled, t_s1, hold_s1, start_s1};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state; the stage frees itself in the cycle that it hands on.
	always_comb begin
		state_d = state_q;
		full = 1'b0;
		mid_push = 1'b0;
		case (state_q)
			FS_EMPTY: begin
				if (push) begin
					state_d = FS_PREV;
				end
			end
			FS_PREV: begin
				full = 1'b1;
				state_d = FS_CUR;
			end
			FS_CUR: begin
				if (mid_full) begin
					full = 1'b1;
				end else begin
					mid_push = 1'b1;
					state_d = push ? FS_PREV : FS_EMPTY;
				end
			end
			default: begin
				state_d = FS_EMPTY;
			end
		endcase
	end

	// Running state carried from sample to sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npos_q <= '0;
			prev_input_q <= '0;
		end else if (accept) begin
			npos_q <= npos_d;
			prev_input_q <= sample;
		end
	end

	// Stage register of the accepted sample.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_raw_s1 <= sample;
			prev_raw_s1 <= prev_input_q;
			hold_s1 <= hold_w;
			start_s1 <= clip_start;
			t_s1 <= t_w;
		end
		if (state_q == FS_PREV) begin
			sprev_s1 <= scaled;
		end
	end

endmodule

FILE: hdl/abd_back.sv
// Back of the bitcrusher: interpolation at hold points, PCM or DPCM level
// choice and the held level. Depends on abd_pkg.
module abd_back
	import abd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int MidW = 2 * (SAMPLE_BITS + 1) + T_W + 2,
	localparam int OutW = SAMPLE_BITS + 1 + 16 + 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic [MidW-1:0] mid_data,
	input  logic            mid_empty,
	output logic            mid_pop,
	output logic            out_push,
	output logic [OutW-1:0] out_data,
	input  logic            out_full
);

	localparam int LW = SAMPLE_BITS + 1;
	localparam int IW = SAMPLE_BITS + 20;
	localparam int QW = SAMPLE_BITS + 2;

	back_state_t state_q;
	back_state_t state_d;

	logic signed [SAMPLE_BITS:0] m_prev;
	logic signed [SAMPLE_BITS:0] m_cur;
	logic [T_W-1:0] m_t;
	logic m_hold;
	logic m_start;

	logic signed [SAMPLE_BITS+1:0] diff;
	logic signed [IW-1:0] iprod;
	logic signed [IW-1:0] irnd;
	logic signed [IW-1:0] vsum;

	logic signed [LW-1:0] v_q;
	logic hold_q;
	logic start_q;
	logic signed [LW-1:0] k0_q;

	logic signed [QW-1:0] qv;
	logic signed [QW-1:0] k0;

	logic signed [SAMPLE_BITS-1:0] held_q;
	logic signed [SAMPLE_BITS-1:0] dpcm_q;

	logic signed [LW-1:0] kmax;
	logic signed [LW-1:0] kmin;
	logic signed [LW-1:0] base;
	logic signed [LW-1:0] halfs;
	logic signed [LW-1:0] bm;
	logic signed [LW-1:0] bp;
	logic signed [LW-1:0] lo;
	logic signed [LW-1:0] hi;
	logic signed [LW-1:0] kc;
	logic signed [LW-1:0] dn;
	logic signed [LW-1:0] up;
	logic signed [LW-1:0] bq;
	logic signed [LW-1:0] dk;
	logic signed [LW-1:0] pcm_k;
	logic signed [LW-1:0] k_new;
	logic signed [LW-1:0] k_out;
	logic signed [LW-1:0] crushed_w;
	logic signed [LW+15:0] lvl_ext;

	function automatic logic signed [LW-1:0] clampv(
		input logic signed [LW-1:0] x,
		input logic signed [LW-1:0] lo_b,
		input logic signed [LW-1:0] hi_b
	);
		logic signed [LW-1:0] r;
		r = x;
		if (r < lo_b) begin
			r = lo_b;
		end
		if (r > hi_b) begin
			r = hi_b;
		end
		return r;
	endfunction

	// Fields of the head entry of the queue from the front.
	assign m_prev = mid_data[MidW-1 -: SAMPLE_BITS + 1];
	assign m_cur = mid_data[MidW-1-(SAMPLE_BITS+1) -: SAMPLE_BITS + 1];
	assign m_t = mid_data[T_W+1:2];
	assign m_hold = mid_data[1];
	assign m_start = mid_data[0];

	// Linear interpolation between the two scaled samples, rounded half up.
	assign diff = $signed({m_cur[SAMPLE_BITS], m_cur}) - $signed({m_prev[SAMPLE_BITS], m_prev});
	assign iprod = diff * $signed({1'b0, m_t});
	assign irnd = (iprod + IW'(HALF_Q16)) >>> 16;
	assign vsum = IW'(m_prev) + irnd;

	// Nearest level, ties to the lower one, before any range limit.
	assign qv = QW'(v_q) + ((QW'(1) <<< cfg.shift) >>> 1) - QW'(1);
	assign k0 = qv >>> cfg.shift;

	// Level range for the current depth.
	assign kmax = LW'(1) <<< (cfg.depth - 5'd1);
	assign kmin = LW'(1) - kmax;
	assign pcm_k = clampv(k0_q, kmin, kmax);

	// DPCM: the nearest level within reach of the clamped base, never the base itself.
	assign base = clampv(start_q ? LW'(0) : LW'(dpcm_q), kmin, kmax);
	assign halfs = LW'(1) <<< (cfg.slope - 3'd1);
	assign bm = base - halfs;
	assign bp = base + halfs;
	assign lo = (bm < kmin) ? kmin : bm;
	assign hi = (bp > kmax) ? kmax : bp;
	assign kc = clampv(k0_q, lo, hi);
	assign dn = base - LW'(1);
	assign up = base + LW'(1);
	assign bq = base <<< cfg.shift;
	assign dk = (kc != base) ? kc :
		(dn < kmin) ? up :
		(up > kmax) ? dn :
		(v_q <= bq) ? dn : up;

	assign k_new = cfg.dpcm ? dk : pcm_k;
	assign k_out = hold_q ? k_new : LW'(held_q);
	assign crushed_w = k_out <<< cfg.shift;
	assign lvl_ext = (LW + 16)'(k_out);
	assign out_data = {crushed_w, lvl_ext[15:0], hold_q};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: interpolate, quantise at a hold point, then hand the result over.
	always_comb begin
		state_d = state_q;
		mid_pop = 1'b0;
		out_push = 1'b0;
		case (state_q)
			BS_IDLE: begin
				if (!mid_empty) begin
					mid_pop = 1'b1;
					state_d = m_hold ? BS_QUANT : BS_EMIT;
				end
			end
			BS_QUANT: begin
				state_d = BS_EMIT;
			end
			BS_EMIT: begin
				if (!out_full) begin
					out_push = 1'b1;
					state_d = BS_IDLE;
				end
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	// Working registers of the item in hand.
	always_ff @(posedge clk) begin
		if (mid_pop) begin
			v_q <= vsum[SAMPLE_BITS:0];
			hold_q <= m_hold;
			start_q <= m_start;
		end
		if (state_q == BS_QUANT) begin
			k0_q <= k0[SAMPLE_BITS:0];
		end
	end

	// Held level and DPCM running level, updated when a hold point leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			dpcm_q <= '0;
		end else if (out_push && hold_q) begin
			held_q <= k_new[SAMPLE_BITS-1:0];
			if (cfg.dpcm) begin
				dpcm_q <= k_new[SAMPLE_BITS-1:0];
			end else if (start_q) begin
				dpcm_q <= '0;
			end
		end
	end

endmodule
